[hw/rtl/pds_pkg.sv]
// Shared types and constants for the PLL divider solver.
// No dependencies; imported by pds_solve and pll_divider_solver_top.
package pds_pkg;

   localparam int unsigned TARGET_W  = 10;
   localparam int unsigned PREDIV_W  = 3;
   localparam int unsigned MULT_W    = 5;
   localparam int unsigned CORE_W    = 4;
   localparam int unsigned BUS_W     = 4;
   localparam int unsigned SLOW_W    = 3;
   localparam int unsigned NUM_K     = 16;
   // target*k with target <= 360 and k <= 16
   localparam int unsigned PROD_W    = 13;
   localparam int unsigned QUOT_W    = PROD_W - 3;

   localparam logic [TARGET_W-1:0] TARGET_MAX = 10'd360;
   localparam logic [PROD_W-1:0]   PROD_LO    = 13'd128;  // 16 * 8
   localparam logic [PROD_W-1:0]   PROD_HI    = 13'd376;  // 47 * 8
   localparam logic [QUOT_W-1:0]   MULT_BASE  = 10'd16;

   // Fallback setting: sysclk = 8 * 36 / 2 = 144
   localparam logic [PREDIV_W-1:0] FB_PREDIV  = 3'd1;
   localparam logic [MULT_W-1:0]   FB_MULT    = 5'd20;
   localparam logic [BUS_W-1:0]    FB_BUS     = 4'd3;
   localparam logic [SLOW_W-1:0]   FB_SLOW    = 3'd7;
   localparam logic [PREDIV_W-1:0] NORM_PREDIV = 3'd0;
   localparam logic [SLOW_W-1:0]   SLOW_MAX   = 3'd7;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 24;

   typedef struct packed {
      logic [PREDIV_W-1:0] pll_prediv;
      logic [MULT_W-1:0]   pll_mult;
      logic [CORE_W-1:0]   core_div;
      logic [BUS_W-1:0]    bus_div;
      logic [SLOW_W-1:0]   slow_div;
      logic                out_of_range;
   } pds_result_type;

endpackage

[hw/rtl/pll_divider_solver_top.sv]
// Top level of the PLL divider solver: input register, solver, result register.
// Depends on pds_pkg and pds_solve.

// Each request carries a target core clock in MHz and yields one response with
// the PLL predivider and multiplier, core, bus and slow divider fields for an
// 8 MHz oscillator. A request is registered, solved combinationally and
// registered again before it appears on the response channel; one request
// per cycle is sustained while responses are taken. Targets above 360 MHz or
// with no fitting divider return the fallback setting with out_of_range set and
// the core field of the last successful solve (zero after reset).
module pll_divider_solver_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [9:0] target_mhz
   input  logic [pds_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [2:0] pll_prediv, [7:3] pll_mult, [11:8] core_div, [15:12] bus_div,
   // [18:16] slow_div
   output logic [pds_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] out_of_range
   output logic                           rsp_tuser
);
   import pds_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic [TARGET_W-1:0] s1_target_ff;
   logic                out_valid_ff, out_valid_in;
   pds_result_type      out_ff;
   logic [CORE_W-1:0]   last_core_ff, last_core_in;
   pds_result_type      solved;
   logic                out_free;
   logic                s1_move;
   logic                req_xfer;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_xfer   = req_tvalid && req_tready;

   assign s1_valid_in  = req_xfer ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign out_valid_in = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
   assign last_core_in = (s1_move && !solved.out_of_range) ? solved.core_div :
                         last_core_ff;

   pds_solve u_solve (
      .target_mhz    (s1_target_ff),
      .last_core_div (last_core_ff),
      .result        (solved)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_core_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         last_core_ff <= last_core_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_target_ff <= req_tdata[TARGET_W-1:0];
      end
      if (s1_move) begin
         out_ff <= solved;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_ff.slow_div, out_ff.bus_div, out_ff.core_div,
                        out_ff.pll_mult, out_ff.pll_prediv};
   assign rsp_tuser  = out_ff.out_of_range;

`ifndef SYNTH
   // Latest result always carries the retained core field
   a_core_tracks: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.core_div == last_core_ff))
      else $error("core_div differs from retained core field");

   a_fallback: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.out_of_range) |->
         (out_ff.pll_prediv == FB_PREDIV && out_ff.pll_mult == FB_MULT))
      else $error("fallback setting wrong");

   a_normal_prediv: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.out_of_range) |-> (out_ff.pll_prediv == NORM_PREDIV))
      else $error("solved result with non-zero predivider");

   // A waiting request is not dropped while the response side is stalled
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(s1_target_ff)))
      else $error("input stage lost a request");
`endif

endmodule

[hw/rtl/pds_solve.sv]
// Combinational solver: checks the sixteen core dividers in parallel and
// derives the PLL, bus and slow settings. Depends on pds_pkg.
module pds_solve (
   input  logic [pds_pkg::TARGET_W-1:0] target_mhz,
   input  logic [pds_pkg::CORE_W-1:0]   last_core_div,
   output pds_pkg::pds_result_type      result
);
   import pds_pkg::*;

   logic [PROD_W-1:0] prod   [NUM_K];
   logic [NUM_K-1:0]  fit;
   logic [NUM_K-1:0]  hit    [8];
   logic [7:0]        any_hit;
   logic [NUM_K-1:0]  best_mask;
   logic [CORE_W-1:0] best_idx;
   logic [QUOT_W-1:0] best_q;
   logic [QUOT_W-1:0] mult_w;
   logic [QUOT_W+3:0] recip;
   logic [QUOT_W+3:0] slow_raw;
   logic              in_range;

   assign in_range = (target_mhz <= TARGET_MAX);

   always_comb begin
      for (int k = 0; k < NUM_K; k++) begin
         prod[k] = PROD_W'(target_mhz) * PROD_W'(k + 1);
         fit[k]  = in_range && (prod[k] >= PROD_LO) && (prod[k] <= PROD_HI);
      end
   end

   // Remainder buckets: hit[r][k] set when divider k+1 fits with remainder r
   always_comb begin
      for (int r = 0; r < 8; r++) begin
         for (int k = 0; k < NUM_K; k++) begin
            hit[r][k] = fit[k] && (prod[k][2:0] == 3'(r));
         end
         any_hit[r] = |hit[r];
      end
   end

   // Lowest non-empty remainder bucket
   always_comb begin
      best_mask = '0;
      for (int r = 7; r >= 0; r--) begin
         if (any_hit[r]) begin
            best_mask = hit[r];
         end
      end
   end

   // First divider in that bucket
   always_comb begin
      best_idx = '0;
      for (int k = NUM_K - 1; k >= 0; k--) begin
         if (best_mask[k]) begin
            best_idx = CORE_W'(k);
         end
      end
   end

   assign best_q = prod[best_idx][PROD_W-1:3];
   assign mult_w = best_q - MULT_BASE;
   // q*13/64 equals q/5 exactly for q in 16..47
   assign recip    = (QUOT_W+4)'(best_q) * (QUOT_W+4)'(13);
   assign slow_raw = recip >> 5;

   always_comb begin
      if (|fit) begin
         result.pll_prediv   = NORM_PREDIV;
         result.pll_mult     = mult_w[MULT_W-1:0];
         result.core_div     = best_idx;
         result.bus_div      = recip[BUS_W+5:6];
         result.slow_div     = (slow_raw > (QUOT_W+4)'(SLOW_MAX)) ? SLOW_MAX :
                               slow_raw[SLOW_W-1:0];
         result.out_of_range = 1'b0;
      end else begin
         result.pll_prediv   = FB_PREDIV;
         result.pll_mult     = FB_MULT;
         result.core_div     = last_core_div;
         result.bus_div      = FB_BUS;
         result.slow_div     = FB_SLOW;
         result.out_of_range = 1'b1;
      end
   end

endmodule
